// File: hdl/arx_pkg.sv
package arx_pkg;

   typedef enum logic [1:0] {
      OP_STEP  = 2'd0,
      OP_WR_A  = 2'd1,
      OP_WR_B  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_A_ORDER       = 2'd0,
      CSR_B_ORDER       = 2'd1,
      CSR_OUTPUT_DELAY  = 2'd2,
      CSR_INITIAL_STATE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_FETCH,
      ACT_BTAP,
      ACT_ATAP,
      ACT_NOP,
      ACT_WRITEBACK,
      ACT_READ_OUT,
      ACT_RESPOND
   } uact_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_STEP,
      COND_B_DONE,
      COND_A_DONE,
      COND_OUT_BUSY
   } ucond_type;

   localparam int PC_W = 3;

   localparam logic [PC_W-1:0] PC_FETCH = 3'd0;
   localparam logic [PC_W-1:0] PC_BTAP  = 3'd1;
   localparam logic [PC_W-1:0] PC_ATAP  = 3'd2;
   localparam logic [PC_W-1:0] PC_DRAIN = 3'd3;
   localparam logic [PC_W-1:0] PC_ROUND = 3'd4;
   localparam logic [PC_W-1:0] PC_READ  = 3'd5;
   localparam logic [PC_W-1:0] PC_RESP  = 3'd6;

   typedef struct packed {
      uact_type        act;
      ucond_type       cond;
      logic [PC_W-1:0] jump_pc;
      logic [PC_W-1:0] next_pc;
   } uword_type;

   // jump_pc is taken when cond holds; tap and respond actions run only when it does not
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         PC_FETCH: w = '{ACT_FETCH,     COND_NO_STEP,  PC_FETCH, PC_BTAP};
         PC_BTAP:  w = '{ACT_BTAP,      COND_B_DONE,   PC_ATAP,  PC_BTAP};
         PC_ATAP:  w = '{ACT_ATAP,      COND_A_DONE,   PC_DRAIN, PC_ATAP};
         PC_DRAIN: w = '{ACT_NOP,       COND_NEVER,    PC_FETCH, PC_ROUND};
         PC_ROUND: w = '{ACT_WRITEBACK, COND_NEVER,    PC_FETCH, PC_READ};
         PC_READ:  w = '{ACT_READ_OUT,  COND_NEVER,    PC_FETCH, PC_RESP};
         PC_RESP:  w = '{ACT_RESPOND,   COND_OUT_BUSY, PC_RESP,  PC_FETCH};
         default:  w = '{ACT_NOP,       COND_NEVER,    PC_FETCH, PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

// File: hdl/arx_model_step.sv
// ARX plant model stepped one request at a time. Opcode write-A / write-B loads one Q2.14
// coefficient; a step request multiplies the B taps against past inputs and the A taps
// against past computed values, one tap per cycle through a single shared 16x16 multiplier,
// adds the noise term, rounds and saturates to Q4.12, and returns the computed value from
// output_delay - 1 steps back (0 acts as 1, larger values clip to MAX_DELAY). A step grows
// longer with b_order + a_order (orders clipped to their maximum); the tap loop of the
// microcode sequencer and the single read port of the computed-history memory set its
// length. A new request is taken while a result waits on the response port. The history
// memory needs no clearing pass after reset.
module arx_model_step
   import arx_pkg::*;
#(
   parameter int MAX_A_ORDER = 8,
   parameter int MAX_B_ORDER = 8,
   parameter int MAX_DELAY   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_sample_in,
   input  logic [2:0]         req_coef_index,
   input  logic signed [15:0] req_coef_value,
   input  logic signed [15:0] req_noise_term,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_model_out,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int HIST  = MAX_A_ORDER + MAX_DELAY;
   localparam int HW    = $clog2(HIST);
   localparam int MAXT  = (MAX_A_ORDER > MAX_B_ORDER) ? MAX_A_ORDER : MAX_B_ORDER;
   localparam int TW    = $clog2(MAXT + 1);
   localparam int AW    = (MAX_A_ORDER > 1) ? $clog2(MAX_A_ORDER) : 1;
   localparam int BW    = (MAX_B_ORDER > 1) ? $clog2(MAX_B_ORDER) : 1;
   localparam int ACC_W = 33 + $clog2(MAX_A_ORDER + MAX_B_ORDER + 1);
   localparam int QW    = ACC_W - 14;

   localparam logic signed [QW-1:0]    QMAX  = QW'(32767);
   localparam logic signed [QW-1:0]    QMIN  = QW'(-32768);
   localparam logic signed [ACC_W-1:0] RHALF = ACC_W'(8192);

   // configuration
   logic [3:0]         a_order_ff;
   logic [3:0]         b_order_ff;
   logic [4:0]         output_delay_ff;

   // coefficient and input-history registers
   logic signed [15:0] a_coefs_ff [MAX_A_ORDER];
   logic signed [15:0] b_coefs_ff [MAX_B_ORDER];
   logic signed [15:0] u_hist_ff  [MAX_B_ORDER];

   // computed-history memory, circular
   logic signed [15:0] hist_mem [HIST];
   logic [HIST-1:0]    hist_vld_ff;
   logic [HW-1:0]      wp_ff;
   logic signed [15:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               hist_we;
   logic [HW-1:0]      hist_waddr;
   logic signed [15:0] hist_wdata;
   logic [HW-1:0]      hist_raddr;

   // sequencer
   logic [PC_W-1:0]    pc_ff;
   logic [TW-1:0]      tap_ff;
   uword_type          uw;
   logic               jump;
   logic               run_act;

   // step operands and datapath
   logic signed [15:0]    sample_ff;
   logic                  s1_vld_ff;
   logic                  s1_is_a_ff;
   logic signed [15:0]    s1_coef_ff;
   logic signed [15:0]    s1_samp_ff;
   logic                  s2_vld_ff;
   logic                  s2_neg_ff;
   logic signed [31:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [15:0]    mul_b;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [QW-1:0]    q_full;
   logic signed [15:0]      y_sat;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_model_out_ff;

   logic [TW-1:0]      na;
   logic [TW-1:0]      nb;
   logic [HW-1:0]      delay_k;
   logic               req_take;
   logic               out_busy;

   function automatic logic [HW-1:0] slot_addr(input logic [HW-1:0] wp, input logic [HW-1:0] k);
      logic [HW:0] s;
      s = {1'b0, wp} + (HW+1)'(HIST - 1) - {1'b0, k};
      if (s >= (HW+1)'(HIST)) begin
         s = s - (HW+1)'(HIST);
      end
      return s[HW-1:0];
   endfunction

   assign na = (32'(a_order_ff) > MAX_A_ORDER) ? TW'(MAX_A_ORDER) : TW'(a_order_ff);
   assign nb = (32'(b_order_ff) > MAX_B_ORDER) ? TW'(MAX_B_ORDER) : TW'(b_order_ff);

   always_comb begin
      if (output_delay_ff == 5'd0) begin
         delay_k = '0;
      end else if (32'(output_delay_ff) > MAX_DELAY) begin
         delay_k = HW'(MAX_DELAY - 1);
      end else begin
         delay_k = HW'(output_delay_ff - 5'd1);
      end
   end

   assign uw        = ucode_rom(pc_ff);
   assign req_ready = (uw.act == ACT_FETCH);
   assign req_take  = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      unique case (uw.cond)
         COND_NEVER:    jump = 1'b0;
         COND_NO_STEP:  jump = !(req_take && (opcode_type'(req_opcode) == OP_STEP));
         COND_B_DONE:   jump = (tap_ff >= nb);
         COND_A_DONE:   jump = (tap_ff >= na);
         COND_OUT_BUSY: jump = out_busy;
         default:       jump = 1'b0;
      endcase
   end

   assign run_act = !jump;

   // memory port selection
   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = wp_ff;
      hist_wdata = y_sat;
      priority if (csr_we && (csr_index_type'(csr_index) == CSR_INITIAL_STATE)) begin
         hist_we    = 1'b1;
         hist_waddr = slot_addr(wp_ff, delay_k);
         hist_wdata = $signed(csr_wdata);
      end else if (uw.act == ACT_WRITEBACK) begin
         hist_we = 1'b1;
      end
   end

   // hold the delayed slot on the read port while the response waits
   assign hist_raddr = ((uw.act == ACT_READ_OUT) || (uw.act == ACT_RESPOND))
                          ? slot_addr(wp_ff, delay_k)
                          : slot_addr(wp_ff, HW'(tap_ff));

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      rd_data_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (hist_we) begin
            hist_vld_ff[hist_waddr] <= 1'b1;
         end
         rd_vld_ff <= hist_vld_ff[hist_raddr];
      end
   end

   // round half up, then saturate
   assign acc_rnd = acc_ff + RHALF;
   assign q_full  = QW'(acc_rnd >>> 14);
   always_comb begin
      priority if (q_full > QMAX) begin
         y_sat = 16'sh7fff;
      end else if (q_full < QMIN) begin
         y_sat = -16'sh8000;
      end else begin
         y_sat = q_full[15:0];
      end
   end

   assign mul_b    = s1_is_a_ff ? (rd_vld_ff ? rd_data_ff : 16'sd0) : s1_samp_ff;
   assign prod_ext = ACC_W'(prod_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_order_ff       <= 4'd1;
         b_order_ff       <= 4'd1;
         output_delay_ff  <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_A_ORDER:       a_order_ff       <= csr_wdata[3:0];
            CSR_B_ORDER:       b_order_ff       <= csr_wdata[3:0];
            CSR_OUTPUT_DELAY:  output_delay_ff  <= csr_wdata[4:0];
            CSR_INITIAL_STATE: ;
            default:           ;
         endcase
      end
   end

   // coefficients and input history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_A_ORDER; j++) begin
            a_coefs_ff[j] <= '0;
         end
         for (int j = 0; j < MAX_B_ORDER; j++) begin
            b_coefs_ff[j] <= '0;
            u_hist_ff[j]  <= '0;
         end
      end else begin
         if (req_take && (opcode_type'(req_opcode) == OP_WR_A)) begin
            for (int j = 0; j < MAX_A_ORDER; j++) begin
               if (32'(req_coef_index) == j) begin
                  a_coefs_ff[j] <= req_coef_value;
               end
            end
         end
         if (req_take && (opcode_type'(req_opcode) == OP_WR_B)) begin
            for (int j = 0; j < MAX_B_ORDER; j++) begin
               if (32'(req_coef_index) == j) begin
                  b_coefs_ff[j] <= req_coef_value;
               end
            end
         end
         if (uw.act == ACT_WRITEBACK) begin
            u_hist_ff[0] <= sample_ff;
            for (int j = 1; j < MAX_B_ORDER; j++) begin
               u_hist_ff[j] <= u_hist_ff[j-1];
            end
         end
      end
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         tap_ff       <= '0;
         wp_ff        <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff     <= jump ? uw.jump_pc : uw.next_pc;
         s1_vld_ff <= run_act && ((uw.act == ACT_BTAP) || (uw.act == ACT_ATAP));
         s2_vld_ff <= s1_vld_ff;

         if ((uw.act == ACT_RESPOND) && run_act) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (uw.act)
            ACT_FETCH: begin
               tap_ff <= '0;
            end
            ACT_BTAP: begin
               if (run_act) begin
                  tap_ff <= tap_ff + TW'(1);
               end else begin
                  tap_ff <= '0;
               end
            end
            ACT_ATAP: begin
               if (run_act) begin
                  tap_ff <= tap_ff + TW'(1);
               end else begin
                  tap_ff <= '0;
               end
            end
            ACT_WRITEBACK: begin
               wp_ff <= (wp_ff == HW'(HIST - 1)) ? '0 : wp_ff + HW'(1);
            end
            ACT_READ_OUT, ACT_RESPOND, ACT_NOP: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (opcode_type'(req_opcode) == OP_STEP)) begin
         sample_ff <= req_sample_in;
         acc_ff    <= ACC_W'(req_noise_term) <<< 14;
      end else if (s2_vld_ff) begin
         acc_ff <= s2_neg_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end

      s1_is_a_ff <= (uw.act == ACT_ATAP);
      s1_coef_ff <= (uw.act == ACT_ATAP) ? a_coefs_ff[tap_ff[AW-1:0]]
                                         : b_coefs_ff[tap_ff[BW-1:0]];
      s1_samp_ff <= u_hist_ff[tap_ff[BW-1:0]];

      prod_ff   <= s1_coef_ff * mul_b;
      s2_neg_ff <= s1_is_a_ff;

      if ((uw.act == ACT_RESPOND) && run_act) begin
         rsp_model_out_ff <= rd_vld_ff ? rd_data_ff : 16'sd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_model_out = rsp_model_out_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_resp_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == PC_RESP))
      else $error("response raised outside the respond step");

   a_tap_bounded: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == PC_BTAP) |-> (tap_ff <= nb)) and ((pc_ff == PC_ATAP) |-> (tap_ff <= na)))
      else $error("tap counter ran past the order");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_ROUND) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("products still in flight at rounding");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_model_out_ff)))
      else $error("pending response dropped or changed");
`endif

endmodule
